>>> hw/rtl/point_to_screen_lookup_core_assert.svh
// assertion macros for the point to screen lookup checker
// expects i_clk and i_rst_n in the scope of use
`ifndef POINT_TO_SCREEN_LOOKUP_CORE_ASSERT_SVH
`define POINT_TO_SCREEN_LOOKUP_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define PTSL_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ptsl assertion failed");

// next-cycle implication, off during reset
`define PTSL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ptsl assertion failed");

// next-cycle implication, checked through reset
`define PTSL_ASSERT_NEXT_RST(name, ante, cons) \
    name: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("ptsl assertion failed");

`endif

>>> hw/rtl/ptsl_pkg.sv
// shared types and constants for the point to screen lookup block
// no dependencies
package ptsl_pkg;

    localparam int MAX_SCREENS_DEF = 16;
    localparam int CNT_W           = 5;
    localparam int IDX_FW          = 4;
    localparam int COORD_W         = 16;
    localparam int SIZE_W          = 15;
    localparam int EXT_W           = 17;
    localparam int DIFF_W          = 18;
    localparam int SQ_W            = 34;
    localparam int DIST_W          = 35;
    localparam int TOK_IDX_W       = 8;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                       cmd;
        logic [IDX_FW-1:0]          entry_index;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic [SIZE_W-1:0]          rect_width;
        logic [SIZE_W-1:0]          rect_height;
    } t_in_beat;

    typedef struct packed {
        logic              found;
        logic              inside_res;
        logic [IDX_FW-1:0] screen_index;
    } t_out_beat;

    // entry write broadcast to the cells
    typedef struct packed {
        logic                     en;
        logic [IDX_FW-1:0]        idx;
        logic signed [EXT_W-1:0]  xoff;
        logic signed [EXT_W-1:0]  yoff;
        logic signed [EXT_W-1:0]  xend;
        logic signed [EXT_W-1:0]  yend;
        logic signed [EXT_W-1:0]  cx;
        logic signed [EXT_W-1:0]  cy;
    } t_wr;

    // query point moving down the chain
    typedef struct packed {
        logic                       valid;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
    } t_pt;

    // running search result moving down the chain
    typedef struct packed {
        logic                  valid;
        logic                  hit;
        logic                  have;
        logic [TOK_IDX_W-1:0]  hit_idx;
        logic [TOK_IDX_W-1:0]  best_idx;
        logic [DIST_W-1:0]     best;
    } t_tok;

endpackage

>>> hw/rtl/point_to_screen_lookup_core.sv
// point to screen lookup: write beat stores an entry, query beat returns the
// containing or nearest screen (a not-found beat when no screens are in use;
// write beats also return that all-zero beat). one item at a time: a new beat
// is taken only after the last result moves to the output register, and the
// point walks the cell chain one cell per cycle. reset: synchronous active low,
// clears control and sets screens_in_use to 1; entries undefined until written
module point_to_screen_lookup_core #(
    parameter int MAX_SCREENS = ptsl_pkg::MAX_SCREENS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  ptsl_pkg::t_in_beat          i_in_beat,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output ptsl_pkg::t_out_beat         o_out_beat,
    input  logic                        i_cfg_we,
    input  logic [ptsl_pkg::CNT_W-1:0]  i_cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_PEND = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic [ptsl_pkg::CNT_W-1:0]   r_screens;
    ptsl_pkg::t_pt                r_pt, n_pt;
    ptsl_pkg::t_out_beat          r_pend, n_pend;
    ptsl_pkg::t_out_beat          r_out;
    logic                         r_ov;
    logic                         w_acc;
    logic                         w_load;
    ptsl_pkg::t_wr                w_wr;
    ptsl_pkg::t_out_beat          w_res;

    ptsl_pkg::t_pt  pt_chain  [MAX_SCREENS+1];
    ptsl_pkg::t_tok tok_chain [MAX_SCREENS+1];

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_load      = (r_state == ST_PEND) && (!r_ov || i_out_ready);
    assign o_out_valid = r_ov;
    assign o_out_beat  = r_out;

    // entry write with precomputed edges and centre
    always_comb begin
        w_wr.en   = w_acc && (i_in_beat.cmd == ptsl_pkg::CMD_WRITE);
        w_wr.idx  = i_in_beat.entry_index;
        w_wr.xoff = {i_in_beat.pos_x[ptsl_pkg::COORD_W-1], i_in_beat.pos_x};
        w_wr.yoff = {i_in_beat.pos_y[ptsl_pkg::COORD_W-1], i_in_beat.pos_y};
        w_wr.xend = w_wr.xoff + {2'b00, i_in_beat.rect_width};
        w_wr.yend = w_wr.yoff + {2'b00, i_in_beat.rect_height};
        w_wr.cx   = w_wr.xoff + {3'b000, i_in_beat.rect_width[ptsl_pkg::SIZE_W-1:1]};
        w_wr.cy   = w_wr.yoff + {3'b000, i_in_beat.rect_height[ptsl_pkg::SIZE_W-1:1]};
    end

    assign pt_chain[0]  = r_pt;
    assign tok_chain[0] = '0;

    for (genvar g = 0; g < MAX_SCREENS; g++) begin : g_cell
        ptsl_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr),
            .i_count (r_screens),
            .i_pt    (pt_chain[g]),
            .i_tok   (tok_chain[g]),
            .o_pt    (pt_chain[g+1]),
            .o_tok   (tok_chain[g+1])
        );
    end

    // final chain result
    always_comb begin
        w_res.found        = 1'b1;
        w_res.inside_res   = tok_chain[MAX_SCREENS].hit;
        w_res.screen_index = tok_chain[MAX_SCREENS].hit ?
                             tok_chain[MAX_SCREENS].hit_idx[ptsl_pkg::IDX_FW-1:0] :
                             tok_chain[MAX_SCREENS].best_idx[ptsl_pkg::IDX_FW-1:0];
    end

    always_comb begin
        n_state  = r_state;
        n_pt     = r_pt;
        n_pt.valid = 1'b0;
        n_pend   = r_pend;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_pt.px = i_in_beat.pos_x;
                    n_pt.py = i_in_beat.pos_y;
                    if ((i_in_beat.cmd == ptsl_pkg::CMD_QUERY) && (r_screens != '0)) begin
                        n_pt.valid = 1'b1;
                        n_state    = ST_RUN;
                    end else begin
                        n_pend  = '0;
                        n_state = ST_PEND;
                    end
                end
            end
            ST_RUN: begin
                if (tok_chain[MAX_SCREENS].valid) begin
                    n_pend  = w_res;
                    n_state = ST_PEND;
                end
            end
            ST_PEND: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pt.valid <= 1'b0;
            r_ov       <= 1'b0;
            r_screens  <= ptsl_pkg::CNT_W'(1);
        end else begin
            r_state    <= n_state;
            r_pt.valid <= n_pt.valid;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                r_screens <= i_cfg_wdata;
            end
        end
        r_pt.px <= n_pt.px;
        r_pt.py <= n_pt.py;
        r_pend  <= n_pend;
        if (w_load) begin
            r_out <= r_pend;
        end
    end

endmodule

>>> hw/rtl/ptsl_cell.sv
// one screen entry of the lookup chain: stores the rectangle, tests the
// point and folds its distance into the running result; uses ptsl_pkg
module ptsl_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ptsl_pkg::t_wr                i_wr,
    input  logic [ptsl_pkg::CNT_W-1:0]   i_count,
    input  ptsl_pkg::t_pt                i_pt,
    input  ptsl_pkg::t_tok               i_tok,
    output ptsl_pkg::t_pt                o_pt,
    output ptsl_pkg::t_tok               o_tok
);

    localparam logic [ptsl_pkg::TOK_IDX_W-1:0] MY_IDX = ptsl_pkg::TOK_IDX_W'(CELL_IDX);
    localparam bit WRITABLE = (CELL_IDX < (1 << ptsl_pkg::IDX_FW));

    logic signed [ptsl_pkg::EXT_W-1:0] r_xoff, r_yoff, r_xend, r_yend, r_cx, r_cy;

    logic                              w_sel;
    logic                              w_use;
    logic signed [ptsl_pkg::EXT_W-1:0] w_px, w_py;
    logic signed [ptsl_pkg::DIFF_W-1:0] w_dx, w_dy;
    logic [ptsl_pkg::EXT_W-1:0]        w_adx, w_ady;
    logic [ptsl_pkg::SQ_W-1:0]         w_sqx, w_sqy;
    logic                              w_hit;

    logic                              r_pv;
    logic                              r_use;
    logic                              r_hit;
    logic [ptsl_pkg::SQ_W-1:0]         r_sqx, r_sqy;
    ptsl_pkg::t_pt                     r_pt;

    logic [ptsl_pkg::DIST_W-1:0]       w_dist;
    ptsl_pkg::t_tok                    n_tok;
    ptsl_pkg::t_tok                    r_tok;

    // entry storage
    assign w_sel = WRITABLE && i_wr.en && (i_wr.idx == ptsl_pkg::IDX_FW'(CELL_IDX));

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_xoff <= i_wr.xoff;
            r_yoff <= i_wr.yoff;
            r_xend <= i_wr.xend;
            r_yend <= i_wr.yend;
            r_cx   <= i_wr.cx;
            r_cy   <= i_wr.cy;
        end
    end

    // point test and squares
    assign w_use = ({{(ptsl_pkg::TOK_IDX_W-ptsl_pkg::CNT_W){1'b0}}, i_count} > MY_IDX);
    assign w_px  = {i_pt.px[ptsl_pkg::COORD_W-1], i_pt.px};
    assign w_py  = {i_pt.py[ptsl_pkg::COORD_W-1], i_pt.py};
    assign w_dx  = {w_px[ptsl_pkg::EXT_W-1], w_px} - {r_cx[ptsl_pkg::EXT_W-1], r_cx};
    assign w_dy  = {w_py[ptsl_pkg::EXT_W-1], w_py} - {r_cy[ptsl_pkg::EXT_W-1], r_cy};
    assign w_adx = w_dx[ptsl_pkg::DIFF_W-1] ? ptsl_pkg::EXT_W'(-w_dx) : w_dx[ptsl_pkg::EXT_W-1:0];
    assign w_ady = w_dy[ptsl_pkg::DIFF_W-1] ? ptsl_pkg::EXT_W'(-w_dy) : w_dy[ptsl_pkg::EXT_W-1:0];
    assign w_sqx = {{(ptsl_pkg::SQ_W-ptsl_pkg::EXT_W){1'b0}}, w_adx}
                 * {{(ptsl_pkg::SQ_W-ptsl_pkg::EXT_W){1'b0}}, w_adx};
    assign w_sqy = {{(ptsl_pkg::SQ_W-ptsl_pkg::EXT_W){1'b0}}, w_ady}
                 * {{(ptsl_pkg::SQ_W-ptsl_pkg::EXT_W){1'b0}}, w_ady};
    assign w_hit = (w_px >= r_xoff) && (w_px <= r_xend) &&
                   (w_py >= r_yoff) && (w_py <= r_yend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv       <= 1'b0;
            r_pt.valid <= 1'b0;
        end else begin
            r_pv       <= i_pt.valid;
            r_pt.valid <= i_pt.valid;
        end
        r_pt.px <= i_pt.px;
        r_pt.py <= i_pt.py;
        r_use   <= w_use;
        r_hit   <= w_hit;
        r_sqx   <= w_sqx;
        r_sqy   <= w_sqy;
    end

    assign o_pt = r_pt;

    // fold into running result
    assign w_dist = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_comb begin
        n_tok       = i_tok;
        n_tok.valid = r_pv;
        if (r_use) begin
            if (!i_tok.hit && r_hit) begin
                n_tok.hit     = 1'b1;
                n_tok.hit_idx = MY_IDX;
            end
            if (!i_tok.have || (w_dist < i_tok.best)) begin
                n_tok.have     = 1'b1;
                n_tok.best     = w_dist;
                n_tok.best_idx = MY_IDX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.hit      <= n_tok.hit;
        r_tok.have     <= n_tok.have;
        r_tok.hit_idx  <= n_tok.hit_idx;
        r_tok.best_idx <= n_tok.best_idx;
        r_tok.best     <= n_tok.best;
    end

    assign o_tok = r_tok;

endmodule

>>> hw/rtl/ptsl_chk.sv
// port-level checker for point_to_screen_lookup_core, bound to the top
// depends on ptsl_pkg and point_to_screen_lookup_core_assert.svh
`include "point_to_screen_lookup_core_assert.svh"

module ptsl_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_ready,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  ptsl_pkg::t_out_beat         o_out_beat
);

    `PTSL_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_beat))
    `PTSL_ASSERT_NOW(a_not_found_zero, o_out_valid && !o_out_beat.found, !o_out_beat.inside_res && (o_out_beat.screen_index == '0))
    `PTSL_ASSERT_NEXT(a_one_at_a_time, i_in_valid && o_in_ready, !o_in_ready)
    `PTSL_ASSERT_NEXT_RST(a_reset_empty, !i_rst_n, !o_out_valid && o_in_ready)

endmodule

bind point_to_screen_lookup_core ptsl_chk u_ptsl_chk (.*);
